// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, ignored while reset is asserted
`define SMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition, ignored while reset is asserted
`define SMF_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: sv/smf_pkg.sv
package smf_pkg;

	// sample width on both sides
	localparam int DATA_W = 16;

	// flags that a cell hands to its right neighbor
	typedef struct packed {
		logic cmp;  // stored value greater than the incoming sample
		logic rem;  // oldest entry sits at this cell or further left
	} smf_flag_t;

endpackage

// File: sv/sliding_median_filter.sv
// running median over the last WINDOW samples, kept as a sorted chain of cells
// result word is registered and offered in the cycle after its sample word is taken
// throughput: one word per cycle while results are taken; each cell updates from its neighbors in one step
// the output register lets a new sample in while the last result is taken
// reset (arst_n low, asynchronous): window holds zeros, output register empty
`include "assert_macros.svh"

module sliding_median_filter #(
	parameter int WINDOW = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [smf_pkg::DATA_W-1:0] s_tdata,  // [15:0] sample
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [smf_pkg::DATA_W-1:0] m_tdata   // [15:0] median
);
	import smf_pkg::*;

	localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MID   = WINDOW / 2;

	logic [DATA_W-1:0] val_w [WINDOW];
	logic [DATA_W-1:0] nxt_w [WINDOW];
	logic [AGE_W-1:0]  age_w [WINDOW];
	smf_flag_t         flag_w [WINDOW];
	logic [WINDOW-1:0] del_vec;
	logic [WINDOW-1:0] order_ok;

	logic              in_fire;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] median_q;

	assign in_fire  = s_tvalid & s_tready;
	assign s_tready = !m_tvalid_q || m_tready;

	// chain of sorted cells
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [DATA_W-1:0] lval;
		logic [AGE_W-1:0]  lage;
		smf_flag_t         lflag;
		logic [DATA_W-1:0] rval;
		logic [AGE_W-1:0]  rage;
		logic              rcmp;

		if (i == 0) begin : g_left_end
			assign lval  = '0;
			assign lage  = '0;
			assign lflag = '{cmp: 1'b0, rem: 1'b0};
		end else begin : g_left
			assign lval  = val_w[i-1];
			assign lage  = age_w[i-1];
			assign lflag = flag_w[i-1];
		end

		if (i == WINDOW - 1) begin : g_right_end
			assign rval = '0;
			assign rage = '0;
			assign rcmp = 1'b1;
		end else begin : g_right
			assign rval = val_w[i+1];
			assign rage = age_w[i+1];
			assign rcmp = flag_w[i+1].cmp;
		end

		smf_cell #(
			.WINDOW (WINDOW),
			.INDEX  (i),
			.AGE_W  (AGE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (in_fire),
			.x         (s_tdata),
			.left_val  (lval),
			.left_age  (lage),
			.left_flag (lflag),
			.right_val (rval),
			.right_age (rage),
			.right_cmp (rcmp),
			.val       (val_w[i]),
			.age       (age_w[i]),
			.flag      (flag_w[i]),
			.nxt_val   (nxt_w[i])
		);

		// checking taps: oldest marker and ascending order
		assign del_vec[i] = age_w[i] == AGE_W'(WINDOW - 1);
		if (i == 0) begin : g_ord_end
			assign order_ok[i] = 1'b1;
		end else begin : g_ord
			assign order_ok[i] = val_w[i-1] <= val_w[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			median_q <= nxt_w[MID];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = median_q;

	`SMF_ASSERT(a_one_oldest, $onehot(del_vec), "window must have exactly one oldest entry")
	`SMF_ASSERT(a_sorted, &order_ok, "cell chain lost ascending order")
	`SMF_ASSERT_NEXT(a_result, in_fire, m_tvalid, "accepted word gave no result word")

endmodule

// File: sv/smf_cell.sv
module smf_cell #(
	parameter int WINDOW = 3,
	parameter int INDEX  = 0,
	parameter int AGE_W  = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [smf_pkg::DATA_W-1:0] x,
	input  logic [smf_pkg::DATA_W-1:0] left_val,
	input  logic [AGE_W-1:0]          left_age,
	input  smf_pkg::smf_flag_t        left_flag,
	input  logic [smf_pkg::DATA_W-1:0] right_val,
	input  logic [AGE_W-1:0]          right_age,
	input  logic                      right_cmp,
	output logic [smf_pkg::DATA_W-1:0] val,
	output logic [AGE_W-1:0]          age,
	output smf_pkg::smf_flag_t        flag,
	output logic [smf_pkg::DATA_W-1:0] nxt_val
);
	import smf_pkg::*;

	localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);
	localparam logic [AGE_W-1:0] AGE_INIT = AGE_W'(INDEX);

	logic [DATA_W-1:0] val_q;
	logic [AGE_W-1:0]  age_q;
	logic [AGE_W-1:0]  nxt_age;
	logic              cmp;
	logic              del;
	logic              at_or_right;

	// local compare and removal detection
	assign cmp         = val_q > x;
	assign del         = age_q == AGE_LAST;
	assign at_or_right = left_flag.rem | del;

	// pick from right neighbor, self, left neighbor or the new sample
	always_comb begin
		if (at_or_right) begin
			if (!right_cmp) begin
				nxt_val = right_val;
				nxt_age = right_age + AGE_W'(1);
			end else if (left_flag.rem ? cmp : left_flag.cmp) begin
				nxt_val = left_flag.rem ? val_q : left_val;
				nxt_age = (left_flag.rem ? age_q : left_age) + AGE_W'(1);
			end else begin
				nxt_val = x;
				nxt_age = '0;
			end
		end else begin
			if (!cmp) begin
				nxt_val = val_q;
				nxt_age = age_q + AGE_W'(1);
			end else if (left_flag.cmp) begin
				nxt_val = left_val;
				nxt_age = left_age + AGE_W'(1);
			end else begin
				nxt_val = x;
				nxt_age = '0;
			end
		end
	end

	// cell storage, window starts as zeros with distinct ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AGE_INIT;
		end else if (load) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

	assign val  = val_q;
	assign age  = age_q;
	assign flag = '{cmp: cmp, rem: at_or_right};

endmodule

// File: sim/sliding_median_filter_tb.sv
module sliding_median_filter_tb;

	import smf_pkg::*;

	localparam int WIN       = 3;
	localparam int HOLD_LEN  = 60;
	localparam int STALL_MAX = 1000;
	localparam int N_RANDOM  = 450;

	// running median predictor with its own window copy and pending medians
	class median_scoreboard;
		logic [DATA_W-1:0] window [WIN];
		int                slot;
		logic [DATA_W-1:0] pending [$];
		int                mismatches;
		int                checked;
		int                noted;

		function new();
			for (int i = 0; i < WIN; i++) window[i] = '0;
			slot       = 0;
			mismatches = 0;
			checked    = 0;
			noted      = 0;
		endfunction

		// one line per mismatch, counted
		function void report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		// sample word taken: overwrite oldest slot, predict the middle of the sorted window
		function void note_sample(logic [DATA_W-1:0] s);
			logic [DATA_W-1:0] ranked [WIN];
			logic [DATA_W-1:0] v;
			int                j;
			window[slot] = s;
			slot = (slot + 1 >= WIN) ? 0 : slot + 1;
			for (int i = 0; i < WIN; i++) ranked[i] = window[i];
			for (int i = 1; i < WIN; i++) begin
				v = ranked[i];
				j = i;
				while (j > 0 && ranked[j-1] > v) begin
					ranked[j] = ranked[j-1];
					j--;
				end
				ranked[j] = v;
			end
			pending.push_back(ranked[WIN/2]);
			noted++;
		endfunction

		// median word taken: compare against oldest prediction
		function void check_median(logic [DATA_W-1:0] got);
			logic [DATA_W-1:0] want;
			if (pending.size() == 0) begin
				report($sformatf("median %04h with no sample pending", got));
			end else begin
				want = pending.pop_front();
				checked++;
				if (got !== want)
					report($sformatf("median got %04h want %04h", got, want));
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [15:0] sample
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;   // [15:0] median

	median_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int hold_served = 0;
	int hold_left   = 0;
	int stall_cnt   = 0;

	sliding_median_filter #(.WINDOW(WIN)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: check taken words, random stalls, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_median(m_tdata);
		if (hold_served != hold_request) begin
			hold_served = hold_request;
			hold_left   = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("timeout after %0d idle cycles", stall_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// offer one sample word and wait until it is taken, then maybe idle
	task automatic send_sample(input logic [DATA_W-1:0] v);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(v);
		// idle cycles drawn one at a time so the idle share follows the percentage
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= DATA_W'($urandom);
			@(posedge clk);
		end
	endtask

	// random sample mix: full range, ties, extremes, single bits
	function automatic logic [DATA_W-1:0] pick_sample();
		case ($urandom_range(5))
			0:       return DATA_W'($urandom_range(7));
			1:       return ($urandom_range(1) == 1) ? '1 : '0;
			2:       return DATA_W'(16'hFFFF - $urandom_range(7));
			3:       return DATA_W'(1) << $urandom_range(DATA_W - 1);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [DATA_W-1:0] directed [$];
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		tx_idle_pct  = 19;
		rx_idle_pct  = 45;
		hold_request = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start-up fill against zeros, extremes, ties, every ordering of three
		directed = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
			16'h0003, 16'h0003, 16'd100, 16'd50, 16'd75, 16'd75, 16'd100, 16'd50,
			16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE, 16'h0000,
			16'hFFFF, 16'h0000};
		foreach (directed[i]) send_sample(directed[i]);

		// sender idles less than receiver
		for (int i = 0; i < N_RANDOM / 3; i++) send_sample(pick_sample());

		// receiver idles less than sender
		tx_idle_pct = 45;
		rx_idle_pct = 19;
		for (int i = 0; i < N_RANDOM / 3; i++) send_sample(pick_sample());

		// no idling, with long receiver hold-offs so the block backs up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request++;
		for (int i = 0; i < N_RANDOM / 3; i++) begin
			if (i == N_RANDOM / 6) hold_request++;
			send_sample(pick_sample());
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d medians never arrived", sb.pending.size()));

		$display("run: %0d samples taken, %0d medians checked over a %0d-wide window",
			sb.noted, sb.checked, WIN);
		$display("run: three idling phases and %0d long receiver hold-offs, %0d mismatches",
			hold_request, sb.mismatches);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
